// File: rtl/nns_pkg.sv
`default_nettype none

package nns_pkg;

    // fixed field widths
    localparam int ADDR_W     = 32;
    localparam int DIM_W      = 13;
    localparam int PITCH_W    = 15;
    localparam int FRAC       = 16;
    localparam int STEP_W     = 29;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 3'd0,
        REG_SOURCE_HEIGHT = 3'd1,
        REG_TARGET_WIDTH  = 3'd2,
        REG_TARGET_HEIGHT = 3'd3,
        REG_KEEP_ASPECT   = 3'd4,
        REG_SOURCE_PITCH  = 3'd5,
        REG_TARGET_PITCH  = 3'd6
    } cfg_reg_t;

    // which quotient the shared divider works on
    typedef enum logic [1:0] {
        SEL_X_STEP = 2'd0,
        SEL_Y_STEP = 2'd1,
        SEL_FRAME_W = 2'd2,
        SEL_FRAME_H = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] src_base;
        logic [ADDR_W-1:0] dst_base;
    } in_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [DIM_W-1:0]  eff_width;
        logic [DIM_W-1:0]  eff_height;
        logic              last;
        logic              no_pixel;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic     latch;
        logic     div_go;
        div_sel_t div_sel;
        logic     step_wr;
        logic     step_copy;
        logic     frame_set;
        logic     mul;
        logic     emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic keep_aspect;
        logic x_lt_y;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/nns_div.sv
`default_nettype none

module nns_div #(
    parameter int N = 29,
    parameter int D = 13
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         go,
    input  wire logic [N-1:0] dividend,
    input  wire logic [D-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [N-1:0]      quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N-1:0]     quo_reg;
    logic [D:0]       rem_reg;
    logic [D-1:0]     dvs_reg;

    logic [D:0]       rem_shift;
    logic [D+1:0]     diff;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_shift = {rem_reg[D-1:0], quo_reg[N-1]};
        diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[D+1])
            begin
                rem_reg <= diff[D:0];
                quo_reg <= {quo_reg[N-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[N-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/nns_dpath.sv
`default_nettype none

module nns_dpath #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic [nns_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [nns_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire nns_pkg::in_word_t                   in_data,
    input  wire nns_pkg::ctrl_cmd_t                  cmd,
    output nns_pkg::dp_status_t                      sts,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output nns_pkg::out_word_t                       out_data
);

    localparam int FW     = $clog2(MAX_DIM + 1);
    localparam int AW     = nns_pkg::STEP_W + FW;
    localparam int DIM_W  = nns_pkg::DIM_W;
    localparam int STEP_W = nns_pkg::STEP_W;
    localparam int ADDR_W = nns_pkg::ADDR_W;
    localparam int FRAC   = nns_pkg::FRAC;

    // configuration registers
    logic [DIM_W-1:0]            cfg_sw_reg, cfg_sh_reg, cfg_dw_reg, cfg_dh_reg;
    logic                        keep_aspect_reg;
    logic [nns_pkg::PITCH_W-1:0] src_pitch_reg, dst_pitch_reg;

    // frame state
    logic [DIM_W-1:0]  sw_reg, sh_reg, dw_reg, dh_reg;
    logic [STEP_W-1:0] x_step_reg, y_step_reg;
    logic [FW-1:0]     frame_width_reg, frame_height_reg;
    logic [FW-1:0]     column_reg, row_reg;
    logic [AW-1:0]     x_accum_reg, y_accum_reg;
    logic [ADDR_W-1:0] src_origin_reg, dst_origin_reg;
    logic              frame_done_reg;
    nns_pkg::div_sel_t sel_reg;

    // products of the current row
    logic [ADDR_W-1:0] y_off_reg, d_off_reg;

    // output slot
    logic               out_valid_reg;
    nns_pkg::out_word_t out_reg;

    // divider
    logic [STEP_W-1:0] div_dividend;
    logic [DIM_W-1:0]  div_divisor;
    logic              div_busy, div_done;
    logic [STEP_W-1:0] div_q;

    logic [DIM_W-1:0]  clamp_sw, clamp_sh, clamp_dw, clamp_dh;
    logic [FW-1:0]     q_sat, fw_new, fh_new;
    logic [ADDR_W-1:0] x_int, y_int;
    logic [ADDR_W+nns_pkg::PITCH_W-1:0] y_prod;
    logic [FW+nns_pkg::PITCH_W-1:0]     d_prod;
    logic [FW-1:0]     col_inc, row_inc;
    logic              is_last, out_free;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    // size clamping for the start word
    always_comb
    begin
        clamp_sw = clamp_dim(cfg_sw_reg);
        clamp_sh = clamp_dim(cfg_sh_reg);
        clamp_dw = clamp_dim(cfg_dw_reg);
        clamp_dh = clamp_dim(cfg_dh_reg);
    end

    // divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            nns_pkg::SEL_X_STEP:
            begin
                div_dividend = STEP_W'({sw_reg, FRAC'(0)});
                div_divisor  = dw_reg;
            end
            nns_pkg::SEL_Y_STEP:
            begin
                div_dividend = STEP_W'({sh_reg, FRAC'(0)});
                div_divisor  = dh_reg;
            end
            nns_pkg::SEL_FRAME_W:
            begin
                div_dividend = STEP_W'(sw_reg) * STEP_W'(dh_reg);
                div_divisor  = sh_reg;
            end
            default:
            begin
                div_dividend = STEP_W'(dw_reg) * STEP_W'(sh_reg);
                div_divisor  = sw_reg;
            end
        endcase
    end

    nns_div #(
        .N (STEP_W),
        .D (DIM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // reduced size saturates at the maximum dimension
    always_comb
    begin
        q_sat  = (div_q > STEP_W'(MAX_DIM)) ? FW'(MAX_DIM) : FW'(div_q);
        fw_new = (sel_reg == nns_pkg::SEL_FRAME_W) ? q_sat : FW'(dw_reg);
        fh_new = (sel_reg == nns_pkg::SEL_FRAME_H) ? q_sat : FW'(dh_reg);
    end

    // pixel address terms
    always_comb
    begin
        x_int    = ADDR_W'(x_accum_reg >> FRAC);
        y_int    = ADDR_W'(y_accum_reg >> FRAC);
        y_prod   = y_int * src_pitch_reg;
        d_prod   = row_reg * dst_pitch_reg;
        col_inc  = column_reg + FW'(1);
        row_inc  = row_reg + FW'(1);
        is_last  = (col_inc == frame_width_reg) && (row_inc == frame_height_reg);
        out_free = !out_valid_reg || !out_stall;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_sw_reg      <= DIM_W'(1);
            cfg_sh_reg      <= DIM_W'(1);
            cfg_dw_reg      <= DIM_W'(1);
            cfg_dh_reg      <= DIM_W'(1);
            keep_aspect_reg <= 1'b0;
            src_pitch_reg   <= '0;
            dst_pitch_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (nns_pkg::cfg_reg_t'(cfg_index))
                nns_pkg::REG_SOURCE_WIDTH:  cfg_sw_reg      <= cfg_data[DIM_W-1:0];
                nns_pkg::REG_SOURCE_HEIGHT: cfg_sh_reg      <= cfg_data[DIM_W-1:0];
                nns_pkg::REG_TARGET_WIDTH:  cfg_dw_reg      <= cfg_data[DIM_W-1:0];
                nns_pkg::REG_TARGET_HEIGHT: cfg_dh_reg      <= cfg_data[DIM_W-1:0];
                nns_pkg::REG_KEEP_ASPECT:   keep_aspect_reg <= cfg_data[0];
                nns_pkg::REG_SOURCE_PITCH:  src_pitch_reg   <= cfg_data;
                nns_pkg::REG_TARGET_PITCH:  dst_pitch_reg   <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_step_reg       <= '0;
            y_step_reg       <= '0;
            frame_width_reg  <= '0;
            frame_height_reg <= '0;
            column_reg       <= '0;
            row_reg          <= '0;
            x_accum_reg      <= '0;
            y_accum_reg      <= '0;
            src_origin_reg   <= '0;
            dst_origin_reg   <= '0;
            frame_done_reg   <= 1'b1;
            sel_reg          <= nns_pkg::SEL_X_STEP;
        end
        else
        begin
            if (cmd.latch)
            begin
                src_origin_reg <= in_data.src_base;
                dst_origin_reg <= in_data.dst_base;
                column_reg     <= '0;
                row_reg        <= '0;
                x_accum_reg    <= '0;
                y_accum_reg    <= '0;
            end
            if (cmd.div_go)
                sel_reg <= cmd.div_sel;
            if (cmd.step_wr)
            begin
                if (sel_reg == nns_pkg::SEL_X_STEP)
                    x_step_reg <= div_q + STEP_W'(1);
                else
                    y_step_reg <= div_q + STEP_W'(1);
            end
            // common ratio is the larger one
            if (cmd.step_copy)
            begin
                if (x_step_reg < y_step_reg)
                    x_step_reg <= y_step_reg;
                else
                    y_step_reg <= x_step_reg;
            end
            if (cmd.frame_set)
            begin
                frame_width_reg  <= fw_new;
                frame_height_reg <= fh_new;
                frame_done_reg   <= (fw_new == '0) || (fh_new == '0);
            end
            // advance in raster order
            if (cmd.emit && !frame_done_reg)
            begin
                if (is_last)
                    frame_done_reg <= 1'b1;
                else if (col_inc >= frame_width_reg)
                begin
                    column_reg  <= '0;
                    x_accum_reg <= '0;
                    row_reg     <= row_inc;
                    y_accum_reg <= y_accum_reg + AW'(y_step_reg);
                end
                else
                begin
                    column_reg  <= col_inc;
                    x_accum_reg <= x_accum_reg + AW'(x_step_reg);
                end
            end
        end
    end

    // clamped sizes latched at start
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            sw_reg <= clamp_sw;
            sh_reg <= clamp_sh;
            dw_reg <= clamp_dw;
            dh_reg <= clamp_dh;
        end
    end

    // row offset products
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            y_off_reg <= ADDR_W'(y_prod);
            d_off_reg <= ADDR_W'(d_prod);
        end
    end

    // output slot valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.eff_width  <= DIM_W'(frame_width_reg);
            out_reg.eff_height <= DIM_W'(frame_height_reg);
            if (frame_done_reg)
            begin
                out_reg.src_addr <= '0;
                out_reg.dst_addr <= '0;
                out_reg.last     <= 1'b0;
                out_reg.no_pixel <= 1'b1;
            end
            else
            begin
                out_reg.src_addr <= src_origin_reg + {x_int[ADDR_W-2:0], 1'b0} + y_off_reg;
                out_reg.dst_addr <= dst_origin_reg + (ADDR_W'(column_reg) << 1) + d_off_reg;
                out_reg.last     <= is_last;
                out_reg.no_pixel <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.div_busy    = div_busy;
        sts.div_done    = div_done;
        sts.keep_aspect = keep_aspect_reg;
        sts.x_lt_y      = x_step_reg < y_step_reg;
        sts.out_free    = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    // a new word never overwrites one still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("emit into occupied output slot");

    // divider is never restarted mid-division
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_go |-> !div_busy)
        else $error("divider started while busy");

    // latched frame sizes stay within the maximum dimension
    a_frame_size: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.frame_set |=> (32'(frame_width_reg) <= MAX_DIM)
                          && (32'(frame_height_reg) <= MAX_DIM))
        else $error("frame size above maximum");

    // the final pixel closes the frame
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !frame_done_reg && is_last) |=> frame_done_reg)
        else $error("frame still open after last pixel");

    // a no_pixel word carries zero addresses and no last mark
    a_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.no_pixel)
            |-> (out_reg.src_addr == '0) && (out_reg.dst_addr == '0) && !out_reg.last)
        else $error("no_pixel word with address fields set");
`endif

endmodule

`default_nettype wire

// File: rtl/nns_ctrl.sv
`default_nettype none

module nns_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_cmd,
    output logic                     in_stall,
    input  wire nns_pkg::dp_status_t sts,
    output nns_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_XGO,
        S_XWAIT,
        S_YGO,
        S_YWAIT,
        S_ASPECT,
        S_FWAIT,
        S_MUL,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg;
    logic   accept;

    assign accept = in_valid && !in_stall_reg;

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = nns_pkg::SEL_X_STEP;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == nns_pkg::CMD_START)
                    begin
                        cmd.latch  = 1'b1;
                        state_next = S_XGO;
                    end
                    else
                        state_next = S_MUL;
                end
            end
            S_XGO:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = nns_pkg::SEL_X_STEP;
                state_next  = S_XWAIT;
            end
            S_XWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.step_wr = 1'b1;
                    state_next  = S_YGO;
                end
            end
            S_YGO:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = nns_pkg::SEL_Y_STEP;
                state_next  = S_YWAIT;
            end
            S_YWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.step_wr = 1'b1;
                    state_next  = S_ASPECT;
                end
            end
            S_ASPECT:
            begin
                if (sts.keep_aspect)
                begin
                    // shrink the axis whose ratio was smaller
                    cmd.step_copy = 1'b1;
                    cmd.div_go    = 1'b1;
                    cmd.div_sel   = sts.x_lt_y ? nns_pkg::SEL_FRAME_W
                                               : nns_pkg::SEL_FRAME_H;
                    state_next    = S_FWAIT;
                end
                else
                begin
                    cmd.frame_set = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_FWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.frame_set = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and input stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

`default_nettype wire

// File: rtl/nearest_neighbour_scaler_addr.sv
`default_nettype none

// channel | direction | handshake               | payload
// in      | input     | in_valid / in_stall     | in_data  (cmd, src_base, dst_base)
// out     | output    | out_valid / out_stall   | out_data (src_addr, dst_addr, eff_width,
//         |           |                         |           eff_height, last, no_pixel)
// cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// next word: accept (S_IDLE), row offset multiply (S_MUL), address add into output register (S_EMIT)
// start word: the shared divider resolves one quotient bit per cycle for each ratio and, with
//   keep_aspect, the reduced size
// one word in flight; the next word is accepted while a result waits in the output register
// out_stall holds the output register; the block then waits before loading the next result
// rst_n clears control state asynchronously; sizes reset to 1, pitches and keep_aspect to 0

module nearest_neighbour_scaler_addr #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire nns_pkg::in_word_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output nns_pkg::out_word_t                  out_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [nns_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nns_pkg::CFG_DATA_W-1:0] cfg_data
);

    nns_pkg::ctrl_cmd_t  cmd;
    nns_pkg::dp_status_t sts;

    // registers always take a write
    assign cfg_ready = 1'b1;

    nns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_data.cmd),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    nns_dpath #(
        .MAX_DIM (MAX_DIM)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// File: tb/nearest_neighbour_scaler_addr_test.sv
module nearest_neighbour_scaler_addr_test;

    import nns_pkg::*;

    localparam int MAX_DIM     = 4096;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_WORDS = 810;

    // tracks frame state and the pixel copies still owed by the block
    class pixel_addr_scoreboard;
        logic [12:0] src_w, src_h, dst_w, dst_h;
        logic        keep;
        logic [14:0] src_pitch, dst_pitch;
        logic [28:0] step_x, step_y;
        logic [12:0] width_eff, height_eff, col, row;
        logic [40:0] acc_x, acc_y;
        logic [31:0] src_org, dst_org;
        bit          frame_idle;
        out_word_t   expected_copies[$];
        int          errors;

        function new();
            src_w = 1;
            src_h = 1;
            dst_w = 1;
            dst_h = 1;
            keep = 0;
            src_pitch = 0;
            dst_pitch = 0;
            step_x = 0;
            step_y = 0;
            width_eff = 0;
            height_eff = 0;
            col = 0;
            row = 0;
            acc_x = 0;
            acc_y = 0;
            src_org = 0;
            dst_org = 0;
            frame_idle = 1;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [14:0] val);
            case (idx)
                REG_SOURCE_WIDTH:  src_w = val[12:0];
                REG_SOURCE_HEIGHT: src_h = val[12:0];
                REG_TARGET_WIDTH:  dst_w = val[12:0];
                REG_TARGET_HEIGHT: dst_h = val[12:0];
                REG_KEEP_ASPECT:   keep = val[0];
                REG_SOURCE_PITCH:  src_pitch = val;
                REG_TARGET_PITCH:  dst_pitch = val;
                default: ;
            endcase
        endfunction

        // zero counts as one, oversize counts as the maximum
        function logic [63:0] clamp_size(logic [12:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_DIM)
                return MAX_DIM;
            return v;
        endfunction

        // ratios and frame size that a start word would latch now
        function void derive_frame(output logic [28:0] sx, output logic [28:0] sy,
                                   output logic [12:0] fw, output logic [12:0] fh);
            logic [63:0] sw, sh, dw, dh, qx, qy, w, h;
            sw = clamp_size(src_w);
            sh = clamp_size(src_h);
            dw = clamp_size(dst_w);
            dh = clamp_size(dst_h);
            qx = ((sw << 16) / dw) + 1;
            qy = ((sh << 16) / dh) + 1;
            w = dw;
            h = dh;
            if (keep)
            begin
                if (qx < qy)
                begin
                    qx = qy;
                    w = (sw * dh) / sh;
                end
                else
                begin
                    qy = qx;
                    h = (dw * sh) / sw;
                end
            end
            if (w > MAX_DIM)
                w = MAX_DIM;
            if (h > MAX_DIM)
                h = MAX_DIM;
            sx = qx[28:0];
            sy = qy[28:0];
            fw = w[12:0];
            fh = h[12:0];
        endfunction

        // predict the copy for an accepted input word
        function void note_word(in_word_t w);
            out_word_t   p;
            logic [63:0] s, d;
            bit          at_end;
            if (w.cmd == CMD_START)
            begin
                derive_frame(step_x, step_y, width_eff, height_eff);
                src_org = w.src_base;
                dst_org = w.dst_base;
                col = 0;
                row = 0;
                acc_x = 0;
                acc_y = 0;
                frame_idle = (width_eff == 0) || (height_eff == 0);
            end
            p = '0;
            p.eff_width = width_eff;
            p.eff_height = height_eff;
            if (frame_idle)
            begin
                p.no_pixel = 1'b1;
            end
            else
            begin
                s = 64'(src_org) + 64'(acc_x[40:16]) * 2 + 64'(acc_y[40:16]) * 64'(src_pitch);
                d = 64'(dst_org) + 64'(col) * 2 + 64'(row) * 64'(dst_pitch);
                at_end = (32'(col) + 1 == 32'(width_eff)) && (32'(row) + 1 == 32'(height_eff));
                p.src_addr = s[31:0];
                p.dst_addr = d[31:0];
                p.last = at_end;
                if (at_end)
                begin
                    frame_idle = 1;
                end
                else
                begin
                    col++;
                    acc_x += 41'(step_x);
                    if (col >= width_eff)
                    begin
                        col = 0;
                        acc_x = 0;
                        row++;
                        acc_y += 41'(step_y);
                    end
                end
            end
            expected_copies.push_back(p);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        // compare an accepted result with the oldest prediction
        function void check_word(out_word_t got);
            out_word_t want;
            if (expected_copies.size() == 0)
            begin
                $display("%0t: result with nothing expected, src %0h dst %0h",
                         $time, got.src_addr, got.dst_addr);
                errors++;
                return;
            end
            want = expected_copies.pop_front();
            compare("src_addr", want.src_addr, got.src_addr);
            compare("dst_addr", want.dst_addr, got.dst_addr);
            compare("eff_width", 32'(want.eff_width), 32'(got.eff_width));
            compare("eff_height", 32'(want.eff_height), 32'(got.eff_height));
            compare("last", 32'(want.last), 32'(got.last));
            compare("no_pixel", 32'(want.no_pixel), 32'(got.no_pixel));
        endfunction

        function int pending();
            return expected_copies.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pixel_addr_scoreboard sb;
    int burst_left;
    int words_sent;
    int cycle_count;
    bit hold_req;
    bit holding;

    nearest_neighbour_scaler_addr #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run time limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // handshake monitor, sees values from before the edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && !in_stall)
                sb.note_word(in_data);
            if (out_valid === 1'b1 && !out_stall)
                sb.check_word(out_data);
        end
    end

    // receiver stall pattern: clean, light and heavy stretches, one long hold on request
    initial
    begin
        int mode;
        int span;
        out_stall <= 1'b0;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                holding = 1;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                holding = 0;
            end
            else
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(10, 120);
                repeat (span)
                begin
                    if (mode == 0)
                        out_stall <= 1'b0;
                    else if (mode == 1)
                        out_stall <= ($urandom_range(0, 3) == 0);
                    else
                        out_stall <= ($urandom_range(0, 3) != 0);
                    @(posedge clk);
                end
            end
        end
    end

    function automatic in_word_t make_word(logic cmd, logic [31:0] src, logic [31:0] dst);
        in_word_t w;
        w.cmd = cmd;
        w.src_base = src;
        w.dst_base = dst;
        return w;
    endfunction

    // size register value, including zero, oversize and masked-off upper bits
    function automatic logic [14:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 15'd0;
            1: return 15'd4096;
            2: return 15'($urandom_range(4097, 32767));
            3: return 15'($urandom_range(1, 4096));
            default: return 15'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [14:0] pick_pitch();
        case ($urandom_range(0, 5))
            0: return 15'd0;
            1: return 15'h7fff;
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    // base near the top of the address space now and then, to force wrap
    function automatic logic [31:0] pick_base();
        if ($urandom_range(0, 3) == 0)
            return 32'hffff_ffff - 32'($urandom_range(0, 255));
        return $urandom();
    endfunction

    // offer one input word, bursts separated by random gaps
    task automatic send_word(in_word_t w);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(100, 300);
            else
                burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    // stop offering and wait for every owed copy
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // write all registers with the block idle
    task automatic configure(logic [14:0] sw, logic [14:0] sh, logic [14:0] tw,
                             logic [14:0] th, logic [14:0] keep, logic [14:0] sp,
                             logic [14:0] tp);
        logic [14:0] vals [7];
        int i;
        vals[REG_SOURCE_WIDTH] = sw;
        vals[REG_SOURCE_HEIGHT] = sh;
        vals[REG_TARGET_WIDTH] = tw;
        vals[REG_TARGET_HEIGHT] = th;
        vals[REG_KEEP_ASPECT] = keep;
        vals[REG_SOURCE_PITCH] = sp;
        vals[REG_TARGET_PITCH] = tp;
        settle();
        for (i = 0; i < 7; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_reg(cfg_reg_t'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [28:0] sx, sy;
        logic [12:0] fw, fh;
        int pixels;
        int count;
        int phase;
        sb = new();
        burst_left = 0;
        words_sent = 0;
        hold_req = 0;
        holding = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SOURCE_WIDTH;
        cfg_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: next with no frame, single pixel frame, next past its end
        send_word(make_word(CMD_NEXT, 32'hffff_ffff, 32'hffff_ffff));
        send_word(make_word(CMD_START, 32'h0, 32'h0));
        send_word(make_word(CMD_NEXT, 32'h0, 32'h0));

        // keep aspect shrinks the width to zero: empty frame
        configure(15'd0, 15'd8191, 15'd1, 15'd1, 15'd1, 15'd0, 15'd0);
        send_word(make_word(CMD_START, 32'h1234_5678, 32'h9abc_def0));
        send_word(make_word(CMD_NEXT, 32'h0, 32'h0));

        // keep aspect with the y ratio larger: width reduced
        configure(15'd2, 15'd8, 15'd4, 15'd4, 15'd1, 15'd3, 15'd5);
        send_word(make_word(CMD_START, 32'h0000_1000, 32'h0000_2000));
        repeat (3) send_word(make_word(CMD_NEXT, 32'h0, 32'h0));

        // keep aspect with the x ratio larger, top pitches, addresses wrapping
        configure(15'd6, 15'd2, 15'd4, 15'd4, 15'h7ffd, 15'h7fff, 15'h7fff);
        send_word(make_word(CMD_START, 32'hffff_fff0, 32'hffff_ffff));
        repeat (4) send_word(make_word(CMD_NEXT, 32'hffff_ffff, 32'h0));

        // maximum and masked sizes, restart in the middle of a frame
        configure(15'd4096, 15'd5, 15'h6003, 15'd2, 15'd0, 15'd1234, 15'd4321);
        send_word(make_word(CMD_START, 32'h8000_0000, 32'h7fff_ffff));
        send_word(make_word(CMD_NEXT, 32'h0, 32'h0));
        send_word(make_word(CMD_START, 32'h5555_5555, 32'haaaa_aaaa));
        repeat (6) send_word(make_word(CMD_NEXT, 32'h0, 32'h0));

        // random settings, mostly whole frames with some noise and cut frames
        phase = 0;
        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            configure(pick_size(), pick_size(), pick_size(), pick_size(),
                      15'($urandom_range(0, 32767)), pick_pitch(), pick_pitch());
            if (phase == 1)
            begin
                // long output hold while input keeps coming
                hold_req = 1;
                while (!holding)
                    @(posedge clk);
                send_word(make_word(CMD_START, pick_base(), pick_base()));
                repeat (40) send_word(make_word(CMD_NEXT, $urandom(), $urandom()));
            end
            repeat ($urandom_range(1, 4))
            begin
                sb.derive_frame(sx, sy, fw, fh);
                pixels = fw * fh;
                send_word(make_word(CMD_START, pick_base(), pick_base()));
                if (pixels == 0 || pixels > 64)
                    count = $urandom_range(0, 24);
                else if ($urandom_range(0, 3) == 0)
                    count = pixels - 1 + $urandom_range(1, 2);
                else
                    count = pixels - 1;
                repeat (count)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_word(make_word(1'($urandom_range(0, 1)), $urandom(), $urandom()));
                    else
                        send_word(make_word(CMD_NEXT, $urandom(), $urandom()));
                end
            end
            if ($urandom_range(0, 3) == 0)
                settle();
            phase++;
        end

        // drain, then watch for stray results
        settle();
        repeat (120) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/nns_pkg.sv
rtl/nns_div.sv
rtl/nns_dpath.sv
rtl/nns_ctrl.sv
rtl/nearest_neighbour_scaler_addr.sv
tb/nearest_neighbour_scaler_addr_test.sv
